### hw/rtl/sil_pkg.sv
// Package for the sorted insertion list: widths, operation codes, cell control.
// No dependencies; used by the interfaces, the cell and the top level.
package sil_pkg;

  localparam int SIL_DATA_W   = 32;
  localparam int SIL_CAPACITY = 16;
  localparam int SIL_CNT_W    = $clog2(SIL_CAPACITY + 1);

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SHOW   = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the incoming value, shifting larger and equal ones up
    logic rotate;  // move every value one cell toward the head, the head value to the last stored cell
  } sil_ctrl_t;

endpackage

### hw/rtl/sil_in_if.sv
// Input channel of the sorted insertion list: valid/ready plus operation and value.
// Depends on sil_pkg.
interface sil_in_if;
  import sil_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SIL_DATA_W-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

### hw/rtl/sil_out_if.sv
// Output channel of the sorted insertion list: valid/ready plus the result fields.
// Depends on sil_pkg.
interface sil_out_if;
  import sil_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SIL_DATA_W-1:0]  item_value;
  logic                          last;
  logic                          empty_res;
  logic                          dropped;

  modport source (output valid, output item_value, output last, output empty_res,
                  output dropped, input ready);
  modport sink   (input valid, input item_value, input last, input empty_res,
                  input dropped, output ready);
endinterface

### hw/rtl/sorted_insertion_list.sv
// Sorted insertion list: keeps up to CAPACITY signed 32-bit values in ascending
// order in a chain of cells. On an insert every cell compares its value with
// the new one in parallel, and the cells at and above the insertion point shift
// up by one while the new value drops into the gap, ahead of any equal values.
// An insert into a full list is dropped and answered with one result flagged
// dropped that carries the refused value. A show transaction streams the stored
// values from the head cell, one result per cycle while the output is taken,
// rotating the chain so that after the last result the list is back in place;
// the final result is marked last. A show on an empty list gives one result
// flagged empty_res. Items are handled one at a time: a show streams its
// results after the accepting cycle, one per stored value, and a new
// transaction is taken once the show has left the chain and the output
// register is free or being drained. No clearing pass is needed after reset.
module sorted_insertion_list #(
  parameter int CAPACITY = sil_pkg::SIL_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  sil_in_if.sink    in,
  sil_out_if.source out
);
  import sil_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // control states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic                          state;
  logic [CNT_W-1:0]              count;     // stored entries
  logic [CNT_W-1:0]              remain;    // results still to stream in a show

  logic                          res_valid;
  logic signed [SIL_DATA_W-1:0]  res_value;
  logic                          res_last;
  logic                          res_empty;
  logic                          res_dropped;

  logic                          accept;
  logic                          slot_free;
  logic                          full;
  logic                          load_drop;
  logic                          load_empty;
  logic                          advance;
  sil_ctrl_t                     ctrl;

  logic signed [SIL_DATA_W-1:0]  cell_value [CAPACITY];
  logic                          cell_sel   [CAPACITY];

  // handshake and command decode
  assign slot_free  = !res_valid || out.ready;
  assign in.ready   = (state == ST_IDLE) && slot_free;
  assign accept     = in.valid && in.ready;
  assign full       = count == CNT_W'(CAPACITY);
  assign load_drop  = accept && (in.operation == OP_INSERT) && full;
  assign load_empty = accept && (in.operation == OP_SHOW) && (count == '0);
  assign advance    = (state == ST_SHOW) && slot_free;

  assign ctrl.insert = accept && (in.operation == OP_INSERT) && !full;
  assign ctrl.rotate = advance;

  // cell chain: prev is the lower neighbor, next the upper one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sil_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .ins_value  (in.value),
      .prev_value ((i == 0) ? in.value : cell_value[(i == 0) ? 0 : i - 1]),
      .prev_sel   ((i == 0) ? 1'b0 : cell_sel[(i == 0) ? 0 : i - 1]),
      .next_value (cell_value[(i == CAPACITY - 1) ? 0 : i + 1]),
      .head_value (cell_value[0]),
      .value      (cell_value[i]),
      .sel        (cell_sel[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        res_valid <= 1'b0;
      end
      if (load_drop || load_empty || advance) begin
        res_valid <= 1'b1;
      end
      if (ctrl.insert) begin
        count <= count + CNT_W'(1);
      end
      if (accept && (in.operation == OP_SHOW) && (count != '0)) begin
        state  <= ST_SHOW;
        remain <= count;
      end
      if (advance) begin
        remain <= remain - CNT_W'(1);
        if (remain == CNT_W'(1)) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_drop) begin
      res_value   <= in.value;
      res_last    <= 1'b1;
      res_empty   <= 1'b0;
      res_dropped <= 1'b1;
    end else if (load_empty) begin
      res_value   <= '0;
      res_last    <= 1'b1;
      res_empty   <= 1'b1;
      res_dropped <= 1'b0;
    end else if (advance) begin
      res_value   <= cell_value[0];
      res_last    <= remain == CNT_W'(1);
      res_empty   <= 1'b0;
      res_dropped <= 1'b0;
    end
  end

  assign out.valid      = res_valid;
  assign out.item_value = res_value;
  assign out.last       = res_last;
  assign out.empty_res  = res_empty;
  assign out.dropped    = res_dropped;

  // checks
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_show_remain : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> (remain != '0) && (remain <= count))
    else $error("show running with bad remaining count");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_flag_last : assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_dropped || res_empty) |-> res_last)
    else $error("single-result transaction not marked last");

  a_no_accept_in_show : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> !accept && !ctrl.insert)
    else $error("transaction taken during show");

endmodule

### hw/rtl/sil_cell.sv
// One storage cell of the sorted list chain: holds a value, compares it with
// the incoming value, takes its lower neighbor's value on insert shift and its upper neighbor's on rotate.
// Depends on sil_pkg.
module sil_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = sil_pkg::SIL_CNT_W
) (
  input  logic                                  clk,
  input  sil_pkg::sil_ctrl_t                    ctrl,
  input  logic [CNT_W-1:0]                      count,
  input  logic signed [sil_pkg::SIL_DATA_W-1:0] ins_value,
  input  logic signed [sil_pkg::SIL_DATA_W-1:0] prev_value,
  input  logic                                  prev_sel,
  input  logic signed [sil_pkg::SIL_DATA_W-1:0] next_value,
  input  logic signed [sil_pkg::SIL_DATA_W-1:0] head_value,
  output logic signed [sil_pkg::SIL_DATA_W-1:0] value,
  output logic                                  sel
);
  import sil_pkg::*;

  logic                          occupied;
  logic                          at_end;
  logic                          wrap;
  logic signed [SIL_DATA_W-1:0]  value_next;

  assign occupied = CNT_W'(INDEX) < count;
  assign at_end   = CNT_W'(INDEX) == count;
  assign wrap     = CNT_W'(INDEX + 1) == count;

  // at or past the insertion point: stored value >= new value, or first free slot
  assign sel = (occupied && (value >= ins_value)) || at_end;

  always_comb begin
    value_next = value;
    if (ctrl.insert) begin
      if (prev_sel) begin
        value_next = prev_value;
      end else if (sel) begin
        value_next = ins_value;
      end
    end else if (ctrl.rotate) begin
      value_next = wrap ? head_value : next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### tb/sil_list_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted insertion list: predicts results from the input channel
// and compares them with the output channel. Depends on sil_pkg, sil_in_if, sil_out_if.
module sil_list_checker #(
  parameter int CAPACITY = sil_pkg::SIL_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  sil_in_if    in_ch,
  sil_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import sil_pkg::*;

  typedef struct {
    logic signed [SIL_DATA_W-1:0] item_value;
    logic                         last;
    logic                         empty_res;
    logic                         dropped;
  } list_result_t;

  list_result_t                 awaited_q[$];
  logic signed [SIL_DATA_W-1:0] sorted_vals[CAPACITY];
  int unsigned                  held;

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] list check: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic list_result_t mk_result(input logic signed [SIL_DATA_W-1:0] v,
                                             input logic l, input logic e,
                                             input logic d);
    list_result_t r;
    r.item_value = v;
    r.last       = l;
    r.empty_res  = e;
    r.dropped    = d;
    return r;
  endfunction

  // Mirror one accepted transaction into the list copy and queue its results.
  task automatic predict_list(input logic op, input logic signed [SIL_DATA_W-1:0] v);
    int unsigned pos;
    if (op == OP_INSERT) begin
      if (held >= CAPACITY) begin
        awaited_q.push_back(mk_result(v, 1'b1, 1'b0, 1'b1));
      end else begin
        pos = held;
        for (int unsigned i = 0; i < held; i++) begin
          if (sorted_vals[i] >= v) begin
            pos = i;
            break;
          end
        end
        for (int unsigned i = held; i > pos; i--)
          sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        held++;
      end
    end else if (held == 0) begin
      awaited_q.push_back(mk_result('0, 1'b1, 1'b1, 1'b0));
    end else begin
      for (int unsigned i = 0; i < held; i++)
        awaited_q.push_back(mk_result(sorted_vals[i], (i + 1 == held), 1'b0, 1'b0));
    end
  endtask

  task automatic check_result();
    list_result_t want;
    if (awaited_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, item_value %0d",
                                out_ch.item_value));
    end else begin
      want = awaited_q.pop_front();
      if (out_ch.item_value !== want.item_value)
        report_mismatch($sformatf("item_value %0d, want %0d", out_ch.item_value,
                                  want.item_value));
      if (out_ch.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", out_ch.last, want.last));
      if (out_ch.empty_res !== want.empty_res)
        report_mismatch($sformatf("empty_res %b, want %b", out_ch.empty_res,
                                  want.empty_res));
      if (out_ch.dropped !== want.dropped)
        report_mismatch($sformatf("dropped %b, want %b", out_ch.dropped, want.dropped));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      awaited_q.delete();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_list(in_ch.operation, in_ch.value);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_result();
    end
    pending <= awaited_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the sorted insertion list testbench: clock, reset, stimulus, output
// back-pressure, watchdog and verdict. Depends on sil_pkg, the interfaces, the
// block and sil_list_checker.
module tb_top;
  import sil_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before the run is abandoned
  localparam int RANDOM_ITEMS   = 480;

  logic clk = 1'b0;
  logic rst;
  bit   calm;        // while set, neither side inserts gaps or stalls
  int   fail_count;
  int   pending;     // results still owed by the block, as seen by the checker
  int   idle_cycles;

  sil_in_if  in_ch();
  sil_out_if out_ch();

  sorted_insertion_list #(.CAPACITY(SIL_CAPACITY)) u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  sil_list_checker #(.CAPACITY(SIL_CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one. Calm
  // stretches give back-to-back traffic on both sides.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean on the corners of the signed range; the rest are uniform.
  function automatic logic signed [SIL_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and hold it until it is taken. valid is left high
  // when no gap follows, so the next call never lowers and raises it in one step.
  task automatic send_item(input logic op, input logic signed [SIL_DATA_W-1:0] v);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until the block has delivered everything it owes.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Toggle calm periods so stretches with and without idling both occur.
  initial begin : pace
    calm <= 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // Output back-pressure: ready drops for random stretches.
  initial begin : sink_ready
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall--;
        end
      end
    end
  end

  // Watchdog: any cycle with no transaction on either channel counts toward
  // the limit; a transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                 (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [SIL_DATA_W-1:0] fill_vals[6];
    logic                         op;
    fill_vals = '{32'sd7, -32'sd100, 32'sd7, 32'sd100, 32'sd7, 32'sd2};
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_INSERT;
    in_ch.value     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: show on the empty list first.
    send_item(OP_SHOW, '0);
    // Signed extremes, zero, +/-1, alternating bit patterns and repeats, so
    // equal values land at the front of their run.
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 32'sh5555_5555);
    send_item(OP_INSERT, 32'shAAAA_AAAA);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_SHOW, '0);
    // Fill up to capacity with a run of equal values in the middle.
    foreach (fill_vals[i])
      send_item(OP_INSERT, fill_vals[i]);
    // The list is full now: both inserts must come back flagged dropped.
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_SHOW, '0);
    wait_drained();

    // Random part: with no delete the list stays full, so inserts exercise
    // the drop path and shows stream the whole list under back-pressure.
    repeat (RANDOM_ITEMS) begin
      op = ($urandom_range(0, 99) < 70) ? OP_INSERT : OP_SHOW;
      send_item(op, pick_value());
      if ($urandom_range(0, 99) < 2)
        wait_drained();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
